// ===== sv/depth_sort_by_distance_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Depth sort assertion macros
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_SORT_BY_DISTANCE_UNIT_MACROS_SVH
`define DEPTH_SORT_BY_DISTANCE_UNIT_MACROS_SVH

// same-cycle implication
`define DSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth sort package
// Shared widths, request and status types and state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int KEY_W      = 52;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int Q_DEPTH    = 8;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_LVL_W    = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    point_t             pt;
    logic [KEY_W-1:0]   key;
    logic               batch_end;
  } req_t;

  typedef struct packed {
    logic               empty;
    logic [Q_LVL_W-1:0] level;
  } q_stat_t;

  typedef enum logic {
    BK_LOAD  = 1'b0,
    BK_DRAIN = 1'b1
  } bk_state_t;

endpackage

`default_nettype wire

// ===== sv/depth_sort_by_distance_unit.sv =====
// ----------------------------------------------------------------------------
// Depth sort by distance unit
// Loads a batch of points and returns them farthest from the center first.
// ----------------------------------------------------------------------------
// Results: a batch_end request passes the key pipeline, the queue and the back
//   end state register; then one result per cycle leaves until the batch is out.
// Flow: the key pipeline takes one request per cycle while busy is low, the
//   insertion chain one per cycle while loading; busy rises while queue and
//   3-stage key pipeline hold 8 requests; the back end pops none while draining.
// Reset: clears center, fill count, overflow flag, queue and state; point
//   store contents stay undefined. Results cannot be stalled by the receiver.
`default_nettype none
`include "depth_sort_by_distance_unit_macros.svh"

module depth_sort_by_distance_unit import dsd_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [COORD_W-1:0]   in_point_x,
  input  wire logic signed [COORD_W-1:0]   in_point_y,
  input  wire logic signed [COORD_W-1:0]   in_point_z,
  input  wire logic                        in_batch_end,
  output logic                             out_valid,
  output logic signed [COORD_W-1:0]        out_sorted_x,
  output logic signed [COORD_W-1:0]        out_sorted_y,
  output logic signed [COORD_W-1:0]        out_sorted_z,
  output logic                             out_final_out,
  output logic                             out_dropped,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [COORD_W-1:0]          cfg_wdata
);

  q_stat_t q_stat;
  logic    push, pop;
  req_t    push_req, pop_req;

  dsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_point_z   (in_point_z),
    .in_batch_end (in_batch_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_stat       (q_stat),
    .push         (push),
    .push_req     (push_req)
  );

  dsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .q_stat   (q_stat)
  );

  dsd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_req       (pop_req),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_sorted_x  (out_sorted_x),
    .out_sorted_y  (out_sorted_y),
    .out_sorted_z  (out_sorted_z),
    .out_final_out (out_final_out),
    .out_dropped   (out_dropped)
  );

  `DSD_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.level <= Q_LVL_W'(Q_DEPTH), "queue overfilled")
  `DSD_ASSERT_NOW(a_full_busy, q_stat.level == Q_LVL_W'(Q_DEPTH), busy, "full queue not busy")
  `DSD_ASSERT_NEXT(a_final_gap, out_valid && out_final_out, !out_valid, "result after final")
  `DSD_ASSERT_NEXT(a_drop_steady, out_valid && !out_final_out, out_valid && (out_dropped == $past(out_dropped)), "batch drain broken")

endmodule

`default_nettype wire

// ===== sv/dsd_front.sv =====
// ----------------------------------------------------------------------------
// Depth sort front end
// Holds the center, takes requests and computes the squared distance key.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_front import dsd_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [COORD_W-1:0]   in_point_x,
  input  wire logic signed [COORD_W-1:0]   in_point_y,
  input  wire logic signed [COORD_W-1:0]   in_point_z,
  input  wire logic                        in_batch_end,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [COORD_W-1:0]          cfg_wdata,
  input  wire q_stat_t                     q_stat,
  output logic                             push,
  output req_t                             push_req
);

  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;

  logic                     v1_r, v2_r, v3_r;
  point_t                   pt1_r, pt2_r, pt3_r;
  logic                     be1_r, be2_r, be3_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r, dz1_r;
  logic [SQ_W-1:0]          sqx2_r, sqy2_r, sqz2_r;
  logic [KEY_W-1:0]         key3_r;

  logic signed [SQ_W-1:0]   prod_x, prod_y, prod_z;
  logic [Q_LVL_W:0]         occ;
  logic                     accept;

  assign occ    = {1'b0, q_stat.level} + (Q_LVL_W+1)'(v1_r) + (Q_LVL_W+1)'(v2_r)
                + (Q_LVL_W+1)'(v3_r);
  assign busy   = occ >= (Q_LVL_W+1)'(Q_DEPTH);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: center_x_r <= cfg_wdata;
        CFG_CENTER_Y: center_y_r <= cfg_wdata;
        CFG_CENTER_Z: center_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign prod_x = dx1_r * dx1_r;
  assign prod_y = dy1_r * dy1_r;
  assign prod_z = dz1_r * dz1_r;

  always_ff @(posedge clk) begin
    pt1_r  <= '{x: in_point_x, y: in_point_y, z: in_point_z};
    be1_r  <= in_batch_end;
    dx1_r  <= DIFF_W'(in_point_x) - DIFF_W'(center_x_r);
    dy1_r  <= DIFF_W'(in_point_y) - DIFF_W'(center_y_r);
    dz1_r  <= DIFF_W'(in_point_z) - DIFF_W'(center_z_r);
    pt2_r  <= pt1_r;
    be2_r  <= be1_r;
    sqx2_r <= prod_x;
    sqy2_r <= prod_y;
    sqz2_r <= prod_z;
    pt3_r  <= pt2_r;
    be3_r  <= be2_r;
    key3_r <= KEY_W'(sqx2_r) + KEY_W'(sqy2_r) + KEY_W'(sqz2_r);
  end

  assign push     = v3_r;
  assign push_req = '{pt: pt3_r, key: key3_r, batch_end: be3_r};

endmodule

`default_nettype wire

// ===== sv/dsd_queue.sv =====
// ----------------------------------------------------------------------------
// Depth sort request queue
// Small FIFO between key computation and the insertion chain.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_queue import dsd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire req_t  push_req,
  input  wire logic  pop,
  output req_t       pop_req,
  output q_stat_t    q_stat
);

  req_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_LVL_W-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   level_r <= level_r + 1'b1;
        2'b01:   level_r <= level_r - 1'b1;
        default: level_r <= level_r;
      endcase
    end
  end

  assign pop_req      = mem[rd_ptr_r];
  assign q_stat.empty = (level_r == '0);
  assign q_stat.level = level_r;

endmodule

`default_nettype wire

// ===== sv/dsd_back.sv =====
// ----------------------------------------------------------------------------
// Depth sort back end
// Insertion chain of held points, sorted farthest first, and batch drain.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_back import dsd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire q_stat_t               q_stat,
  input  wire req_t                  pop_req,
  output logic                       pop,
  output logic                       out_valid,
  output logic signed [COORD_W-1:0]  out_sorted_x,
  output logic signed [COORD_W-1:0]  out_sorted_y,
  output logic signed [COORD_W-1:0]  out_sorted_z,
  output logic                       out_final_out,
  output logic                       out_dropped
);

  bk_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt, fill_after;
  logic             ovf_r, ovf_nxt, ovf_after;

  logic [KEY_W-1:0] key_r   [MAX_POINTS];
  logic [KEY_W-1:0] key_nxt [MAX_POINTS];
  point_t           pt_r    [MAX_POINTS];
  point_t           pt_nxt  [MAX_POINTS];

  logic [MAX_POINTS-1:0] ge;
  logic                  insert;

  logic   out_valid_nxt, out_valid_r;
  point_t out_pt_nxt, out_pt_r;
  logic   out_final_nxt, out_final_r;
  logic   out_dropped_nxt, out_dropped_r;

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      ge[i] = (CNT_W'(i) < fill_r) && (key_r[i] >= pop_req.key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    ovf_nxt         = ovf_r;
    pop             = 1'b0;
    insert          = 1'b0;
    fill_after      = fill_r;
    ovf_after       = ovf_r;
    out_valid_nxt   = 1'b0;
    out_pt_nxt      = pt_r[0];
    out_final_nxt   = (fill_r == CNT_W'(1));
    out_dropped_nxt = ovf_r;
    for (int i = 0; i < MAX_POINTS; i++) begin
      key_nxt[i] = key_r[i];
      pt_nxt[i]  = pt_r[i];
    end
    case (state_r)
      BK_LOAD: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (fill_r < CNT_W'(MAX_POINTS)) begin
            insert     = 1'b1;
            fill_after = fill_r + 1'b1;
          end else begin
            ovf_after = 1'b1;
          end
          fill_nxt = fill_after;
          ovf_nxt  = ovf_after;
          if (pop_req.batch_end) begin
            if (fill_after == '0) begin
              ovf_nxt = 1'b0;
            end else begin
              state_nxt = BK_DRAIN;
            end
          end
        end
      end
      BK_DRAIN: begin
        out_valid_nxt = 1'b1;
        fill_nxt      = fill_r - 1'b1;
        for (int i = 0; i < MAX_POINTS - 1; i++) begin
          key_nxt[i] = key_r[i+1];
          pt_nxt[i]  = pt_r[i+1];
        end
        if (fill_r == CNT_W'(1)) begin
          state_nxt = BK_LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: state_nxt = BK_LOAD;
    endcase
    if (insert) begin
      if (!ge[0]) begin
        key_nxt[0] = pop_req.key;
        pt_nxt[0]  = pop_req.pt;
      end
      for (int i = 1; i < MAX_POINTS; i++) begin
        if (!ge[i]) begin
          if (ge[i-1]) begin
            key_nxt[i] = pop_req.key;
            pt_nxt[i]  = pop_req.pt;
          end else begin
            key_nxt[i] = key_r[i-1];
            pt_nxt[i]  = pt_r[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      key_r[i] <= key_nxt[i];
      pt_r[i]  <= pt_nxt[i];
    end
    out_pt_r      <= out_pt_nxt;
    out_final_r   <= out_final_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_sorted_x  = out_pt_r.x;
  assign out_sorted_y  = out_pt_r.y;
  assign out_sorted_z  = out_pt_r.z;
  assign out_final_out = out_final_r;
  assign out_dropped   = out_dropped_r;

endmodule

`default_nettype wire
